// ===== src/bevrws_pkg.sv =====
// Shared types and constants of the bird's-eye row white-run scanner.
`timescale 1ns / 1ps

package bevrws_pkg;

  localparam int PIX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int IDX_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MIN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN       = 2'd3;

  localparam logic [7:0]  GRAY_THRESHOLD_RST = 8'd128;
  localparam logic [8:0]  UNKNOWN_MIN_RST    = 9'd0;
  localparam logic [8:0]  WHITE_MIN_RST      = 9'd0;
  localparam logic [11:0] MIN_SPAN_RST       = 12'd24;

  localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [7:0] BAND2_MIN = 8'd64;
  localparam logic [7:0] BAND2_MAX = 8'd144;

  // result kinds on m_axis_tuser
  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mult;
    logic interp;
    logic update;
    logic sel_tot;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_hit;
    logic row_end;
  } status_t;

endpackage

// ===== src/bevrws_ctrl.sv =====
// Sequencer of the row scanner: handshakes and step order.
`timescale 1ns / 1ps

module bevrws_ctrl
  import bevrws_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  output logic    m_tvalid_o,
  input  logic    m_tready_i,
  output logic    m_tlast_o,
  output logic    m_tuser_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MULT    = 3'd1;
  localparam logic [2:0] ST_INTERP  = 3'd2;
  localparam logic [2:0] ST_UPDATE  = 3'd3;
  localparam logic [2:0] ST_OUT_RUN = 3'd4;
  localparam logic [2:0] ST_OUT_TOT = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    s_tready_o  = 1'b0;
    m_tvalid_o  = 1'b0;
    m_tlast_o   = 1'b0;
    m_tuser_o   = KIND_RUN;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (status_i.run_hit) begin
          state_d = ST_OUT_RUN;
        end else if (status_i.row_end) begin
          state_d = ST_OUT_TOT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT_RUN: begin
        m_tvalid_o = 1'b1;
        m_tlast_o  = !status_i.row_end;
        if (m_tready_i) begin
          state_d = status_i.row_end ? ST_OUT_TOT : ST_IDLE;
        end
      end
      ST_OUT_TOT: begin
        m_tvalid_o    = 1'b1;
        m_tlast_o     = 1'b1;
        m_tuser_o     = KIND_TOTALS;
        cmd_o.sel_tot = 1'b1;
        if (m_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_o && m_tvalid_o))
    else $error("input accepted while a result is pending");

  a_totals_close_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> m_tlast_o)
    else $error("row totals not flagged as final result");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i && m_tlast_o) |=> s_tready_o)
    else $error("not ready after final result of an item");

  a_capture_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> ##2 cmd_o.update)
    else $error("accepted item not processed in sequence");
`endif

endmodule

// ===== src/bevrws_datapath.sv =====
// Datapath: interpolation, classification, row state, runs and totals.
`timescale 1ns / 1ps

module bevrws_datapath
  import bevrws_pkg::*;
#(
  parameter int MAX_LATERAL_SAMPLES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  in_ok_i,
  input  logic                  in_eor_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int PW = (MAX_LATERAL_SAMPLES > 2) ? $clog2(MAX_LATERAL_SAMPLES) : 1;
  localparam int XW = (PW > IDX_W) ? PW : IDX_W;
  localparam int SW = ((PW + 4) > 12) ? (PW + 4) : 12;
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_LATERAL_SAMPLES - 1);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < COUNT_MAX) ? v + 1'b1 : COUNT_MAX;
  endfunction

  // configuration
  logic [7:0]  thr_q;
  logic [8:0]  umin_q, wmin_q;
  logic [11:0] span_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= GRAY_THRESHOLD_RST;
      umin_q     <= UNKNOWN_MIN_RST;
      wmin_q     <= WHITE_MIN_RST;
      span_min_q <= MIN_SPAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRAY_THRESHOLD: thr_q      <= cfg_data_i[7:0];
        CFG_UNKNOWN_MIN:    umin_q     <= cfg_data_i[8:0];
        CFG_WHITE_MIN:      wmin_q     <= cfg_data_i[8:0];
        CFG_MIN_SPAN:       span_min_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [PIX_W-1:0] tl_q, tr_q, bl_q, br_q, rf_q, cf_q;
  logic             ok_q, eor_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tl_q  <= in_data_i[7:0];
      tr_q  <= in_data_i[15:8];
      bl_q  <= in_data_i[23:16];
      br_q  <= in_data_i[31:24];
      rf_q  <= in_data_i[39:32];
      cf_q  <= in_data_i[47:40];
      ok_q  <= in_ok_i;
      eor_q <= in_eor_i;
    end
  end

  // step 1: horizontal blends, a + (b - a) * f
  logic signed [8:0]  dtop, dbot;
  logic signed [17:0] ptop, pbot, stop, sbot;
  logic [16:0]        top_q, bot_q;

  assign dtop = $signed({1'b0, tr_q}) - $signed({1'b0, tl_q});
  assign dbot = $signed({1'b0, br_q}) - $signed({1'b0, bl_q});
  assign ptop = dtop * $signed({1'b0, cf_q});
  assign pbot = dbot * $signed({1'b0, cf_q});
  assign stop = $signed({1'b0, tl_q, 8'b0}) + ptop;
  assign sbot = $signed({1'b0, bl_q, 8'b0}) + pbot;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      top_q <= stop[16:0];
      bot_q <= sbot[16:0];
    end
  end

  // step 2: vertical blend, rounding, decision products
  logic [7:0]         lo, hi, sat_near, b2;
  logic signed [17:0] dg;
  logic signed [26:0] pg, sg;
  logic [26:0]        rnd;
  logic [7:0]         gray_q;
  logic [16:0]        uprod_q, wprod_q;

  assign lo       = (thr_q == 8'd0) ? 8'd1 : thr_q;
  assign hi       = (thr_q == 8'd255) ? 8'd1 : 8'd255 - thr_q;
  assign sat_near = (lo < hi) ? lo : hi;
  assign b2       = (sat_near < BAND2_MIN) ? BAND2_MIN :
                    (sat_near > BAND2_MAX) ? BAND2_MAX : sat_near;

  assign dg  = $signed({1'b0, bot_q}) - $signed({1'b0, top_q});
  assign pg  = dg * $signed({1'b0, rf_q});
  assign sg  = $signed({2'b0, top_q, 8'b0}) + pg;
  assign rnd = 27'(sg) + 27'd32768;

  always_ff @(posedge clk_i) begin
    if (cmd_i.interp) begin
      gray_q  <= rnd[23:16];
      uprod_q <= 17'(umin_q) * 17'(b2);
      wprod_q <= 17'(wmin_q) * 17'(b2);
    end
  end

  // step 3: classify
  logic [7:0]  mag;
  logic [8:0]  c2, cc;
  logic [16:0] cs;
  logic        bright, unk, is_white, is_black;

  assign mag      = (gray_q > thr_q) ? gray_q - thr_q : thr_q - gray_q;
  assign c2       = {mag, 1'b0};
  assign cc       = (c2 > {1'b0, b2}) ? {1'b0, b2} : c2;
  assign cs       = {cc, 8'b0};
  assign bright   = gray_q > thr_q;
  assign unk      = (cs < uprod_q) || (bright && (cs < wprod_q));
  assign is_white = ok_q && !unk && bright;
  assign is_black = ok_q && !unk && !bright;

  // row state
  logic [PW-1:0]    pos_q, run_start_q, reach_lo_q, reach_hi_q;
  logic             run_open_q, reach_seen_q;
  logic [CNT_W-1:0] white_q, black_q, unk_q, na_q;

  logic [CNT_W-1:0] white_n, black_n, unk_n, na_n, sum_n;
  logic [CNT_W+1:0] sum_w;
  logic [PW-1:0]    reach_lo_n, reach_hi_n, start_n, right_close, cand_l, cand_r, span;
  logic             reach_seen_n, close_run, cand;
  logic [SW-1:0]    span_s;

  assign white_n = is_white ? sat_inc(white_q) : white_q;
  assign black_n = is_black ? sat_inc(black_q) : black_q;
  assign unk_n   = (ok_q && unk) ? sat_inc(unk_q) : unk_q;
  assign na_n    = !ok_q ? sat_inc(na_q) : na_q;
  assign sum_w   = (CNT_W+2)'(white_n) + (CNT_W+2)'(black_n) + (CNT_W+2)'(unk_n);
  assign sum_n   = (sum_w > (CNT_W+2)'(COUNT_MAX)) ? COUNT_MAX : sum_w[CNT_W-1:0];

  assign reach_seen_n = reach_seen_q || ok_q;
  assign reach_lo_n   = !ok_q ? reach_lo_q :
                        (!reach_seen_q || pos_q < reach_lo_q) ? pos_q : reach_lo_q;
  assign reach_hi_n   = !ok_q ? reach_hi_q :
                        (!reach_seen_q || pos_q > reach_hi_q) ? pos_q : reach_hi_q;

  // at most one run closes per item: a non-white item, or a white one at row end
  assign close_run   = !is_white && run_open_q;
  assign start_n     = run_open_q ? run_start_q : pos_q;
  assign right_close = (pos_q == '0) ? '0 : pos_q - 1'b1;
  assign cand_l      = close_run ? run_start_q : start_n;
  assign cand_r      = close_run ? right_close : pos_q;
  assign cand        = close_run || (is_white && eor_q);
  assign span        = (cand_r >= cand_l) ? cand_r - cand_l : '0;
  assign span_s      = SW'({span, 4'b0});

  assign status_o.run_hit = cand && (span_s >= SW'(span_min_q));
  assign status_o.row_end = eor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      run_open_q   <= 1'b0;
      run_start_q  <= '0;
      white_q      <= '0;
      black_q      <= '0;
      unk_q        <= '0;
      na_q         <= '0;
      reach_seen_q <= 1'b0;
      reach_lo_q   <= '0;
      reach_hi_q   <= '0;
    end else if (cmd_i.update) begin
      if (eor_q) begin
        pos_q        <= '0;
        run_open_q   <= 1'b0;
        run_start_q  <= '0;
        white_q      <= '0;
        black_q      <= '0;
        unk_q        <= '0;
        na_q         <= '0;
        reach_seen_q <= 1'b0;
        reach_lo_q   <= '0;
        reach_hi_q   <= '0;
      end else begin
        if (pos_q != POS_LAST) begin
          pos_q <= pos_q + 1'b1;
        end
        run_open_q   <= is_white;
        run_start_q  <= start_n;
        white_q      <= white_n;
        black_q      <= black_n;
        unk_q        <= unk_n;
        na_q         <= na_n;
        reach_seen_q <= reach_seen_n;
        reach_lo_q   <= reach_lo_n;
        reach_hi_q   <= reach_hi_n;
      end
    end
  end

  // result holding registers
  logic [PW-1:0]    run_l_q, run_r_q, tot_rl_q, tot_rr_q;
  logic [CNT_W-1:0] tot_w_q, tot_b_q, tot_u_q, tot_na_q, tot_sum_q;
  logic             tot_rp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      run_l_q   <= cand_l;
      run_r_q   <= cand_r;
      tot_w_q   <= white_n;
      tot_b_q   <= black_n;
      tot_u_q   <= unk_n;
      tot_na_q  <= na_n;
      tot_sum_q <= sum_n;
      tot_rp_q  <= reach_seen_n;
      tot_rl_q  <= reach_lo_n;
      tot_rr_q  <= reach_hi_n;
    end
  end

  logic [XW-1:0] run_l_x, run_r_x, rl_x, rr_x;

  assign run_l_x = XW'(run_l_q);
  assign run_r_x = XW'(run_r_q);
  assign rl_x    = XW'(tot_rl_q);
  assign rr_x    = XW'(tot_rr_q);

  assign out_data_o = cmd_i.sel_tot ?
      {2'b0, rr_x[7:0], rl_x[7:0], tot_rp_q, tot_sum_q, tot_na_q, tot_u_q, tot_b_q,
       tot_w_q, 16'b0} :
      {64'b0, run_r_x[7:0], run_l_x[7:0]};

endmodule

// ===== src/bev_row_white_run_scanner.sv =====
// Top level of the bird's-eye row white-run scanner.
//
//   channel  handshake                     payload
//   s_axis   s_axis_tvalid/s_axis_tready   tdata pixels+fractions, tuser ok, tlast row end
//   m_axis   m_axis_tvalid/m_axis_tready   tdata run/totals, tuser kind, tlast final
//   cfg      cfg_we_i                      cfg_index_i, cfg_data_i
//
// Each accepted item goes through capture, blend, blend and round, and classify and
// update in that order; any results then leave on m_axis one per handshake.
// The sequencer holds one item at a time: s_axis_tready is high only when idle.
// Reset is asynchronous, active low; it restores the configuration registers and clears row state.
// m_axis stalls hold the result and the sequencer in place.
`timescale 1ns / 1ps

module bev_row_white_run_scanner
  import bevrws_pkg::*;
#(
  parameter int MAX_LATERAL_SAMPLES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tl[7:0] tr[15:8] bl[23:16] br[31:24] row_fraction[39:32] col_fraction[47:40]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,  // sample_ok
  input  logic                  s_axis_tlast,  // end_of_row
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // run_left[7:0] run_right[15:8] white[24:16] black[33:25] unknown[42:34]
  // unavailable[51:43] sampleable[60:52] reach_present[61] reach_left[69:62]
  // reach_right[77:70], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,  // result_kind
  output logic                  m_axis_tlast   // last result of the item
);

  cmd_t    cmd;
  status_t status;

  bevrws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bevrws_datapath #(
    .MAX_LATERAL_SAMPLES (MAX_LATERAL_SAMPLES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_ok_i     (s_axis_tuser),
    .in_eor_i    (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

endmodule
